/* rtl/core/cpe_pkg.sv */
// Shared types, widths, codes and the saturation helper for the complex polynomial evaluator.
package cpe_pkg;

    // Q16.16 word width and the fixed transfer widths.
    localparam int Q_W       = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * Q_W - FRAC_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int COEF_W    = 2 * Q_W;
    localparam int CIDX_W    = 4;
    localparam int DEG_W     = 4;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;

    // Request kinds carried in s_tuser.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_EVAL  = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } cpe_state_t;

    // Step controls from the sequencer to the multiply-add datapath.
    typedef struct packed {
        logic load_acc;
        logic mul_en;
        logic add_en;
    } cpe_step_t;

    // Clamp a wide sum to the signed Q16.16 range; the top bit flags a clamp.
    function automatic logic [Q_W:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic             ovf;
        logic [Q_W-1:0]   val;
        ovf = (v[SUM_W-1:Q_W-1] != '0) && (v[SUM_W-1:Q_W-1] != '1);
        if (!ovf) begin
            val = v[Q_W-1:0];
        end else if (v[SUM_W-1]) begin
            val = {1'b1, {(Q_W-1){1'b0}}};
        end else begin
            val = {1'b0, {(Q_W-1){1'b1}}};
        end
        return {ovf, val};
    endfunction

endpackage

/* rtl/core/cpe_coef_mem.sv */
// Coefficient store: synchronous memory with per-entry valid bits so unwritten entries read as zero.
module cpe_coef_mem
    import cpe_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [COEF_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [COEF_W-1:0] rd_data
);

    logic [COEF_W-1:0] mem_reg [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [COEF_W-1:0] rdata_reg;
    logic              rvalid_reg;

    // Storage array write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem_reg[rd_addr];
        end
    end

    // Valid bits model the all-zero state after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rvalid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : '0;

endmodule

/* rtl/core/cpe_cmac.sv */
// Complex multiply-add datapath for one Horner step: registered products, then sum and saturate.
module cpe_cmac
    import cpe_pkg::*;
(
    input  logic                    aclk,
    input  cpe_step_t               step,
    input  logic signed [Q_W-1:0]   z_re,
    input  logic signed [Q_W-1:0]   z_im,
    input  logic [COEF_W-1:0]       coef,
    output logic signed [Q_W-1:0]   acc_re,
    output logic signed [Q_W-1:0]   acc_im,
    output logic                    sat_flag
);

    logic signed [Q_W-1:0]    acc_re_reg;
    logic signed [Q_W-1:0]    acc_im_reg;
    logic                     sat_reg;
    logic signed [PROD_W-1:0] p_rr_reg;
    logic signed [PROD_W-1:0] p_ii_reg;
    logic signed [PROD_W-1:0] p_ri_reg;
    logic signed [PROD_W-1:0] p_ir_reg;

    logic signed [2*Q_W-1:0]  prod_rr;
    logic signed [2*Q_W-1:0]  prod_ii;
    logic signed [2*Q_W-1:0]  prod_ri;
    logic signed [2*Q_W-1:0]  prod_ir;
    logic signed [Q_W-1:0]    coef_re;
    logic signed [Q_W-1:0]    coef_im;
    logic signed [SUM_W-1:0]  sum_re;
    logic signed [SUM_W-1:0]  sum_im;
    logic [Q_W:0]             sat_re;
    logic [Q_W:0]             sat_im;

    assign coef_re = coef[Q_W-1:0];
    assign coef_im = coef[2*Q_W-1:Q_W];

    // Four exact partial products; dropping the low fraction bits floors them.
    assign prod_rr = acc_re_reg * z_re;
    assign prod_ii = acc_im_reg * z_im;
    assign prod_ri = acc_re_reg * z_im;
    assign prod_ir = acc_im_reg * z_re;

    // Exact sums of the floored products and the next coefficient.
    assign sum_re = SUM_W'(p_rr_reg) - SUM_W'(p_ii_reg) + SUM_W'(coef_re);
    assign sum_im = SUM_W'(p_ri_reg) + SUM_W'(p_ir_reg) + SUM_W'(coef_im);
    assign sat_re = sat_q(sum_re);
    assign sat_im = sat_q(sum_im);

    // Product stage.
    always_ff @(posedge aclk) begin
        if (step.mul_en) begin
            p_rr_reg <= prod_rr[2*Q_W-1:FRAC_W];
            p_ii_reg <= prod_ii[2*Q_W-1:FRAC_W];
            p_ri_reg <= prod_ri[2*Q_W-1:FRAC_W];
            p_ir_reg <= prod_ir[2*Q_W-1:FRAC_W];
        end
    end

    // Accumulator: loaded with the top coefficient, then updated once per step.
    always_ff @(posedge aclk) begin
        if (step.load_acc) begin
            acc_re_reg <= coef_re;
            acc_im_reg <= coef_im;
            sat_reg    <= 1'b0;
        end else if (step.add_en) begin
            acc_re_reg <= sat_re[Q_W-1:0];
            acc_im_reg <= sat_im[Q_W-1:0];
            sat_reg    <= sat_reg | sat_re[Q_W] | sat_im[Q_W];
        end
    end

    assign acc_re   = acc_re_reg;
    assign acc_im   = acc_im_reg;
    assign sat_flag = sat_reg;

endmodule

/* rtl/core/complex_polynomial_eval.sv */
// Top level of the complex polynomial evaluator: sequencer, handshakes and configuration.
//
// Input channel (s_*): s_tuser selects the request. A write transfer stores the
// Q16.16 complex value in s_tdata into coefficient slot coef_index and gives no
// result; slots above MAX_DEGREE are ignored. An evaluate transfer carries z and
// gives one result transfer with p(z), evaluated by Horner's rule from the
// coefficient at the configured degree (clamped to MAX_DEGREE) down to slot 0.
// Output channel (m_*): result in m_tdata, sticky saturation flag in m_tuser.
// Configuration: cfg_we with cfg_wdata writes the degree; write it only when idle.
// Timing: a write leaves the sequencer idle. An evaluate holds s_tready low until
// its result is loaded, d being the effective degree: first the read of the top
// coefficient returns, then each of the d Horner steps runs (product stage, then add
// and saturate in the single shared complex multiply-add), then the output register
// is loaded. The next input transfer is taken while a result waits.
// If the receiver stalls and the output register is still full, the block
// holds the finished result internally until the register frees.
// Reset clears the degree, the output valid and all coefficients to zero.
module complex_polynomial_eval
    import cpe_pkg::*;
#(
    parameter int MAX_DEGREE = 15
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [DEG_W-1:0]     cfg_wdata,    // degree
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // coef_index, operand_re, operand_im, zero fill
    input  logic                 s_tuser,      // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,      // result_re, result_im
    output logic                 m_tuser       // saturated
);

    localparam int DEPTH = MAX_DEGREE + 1;
    localparam int IDX_W = $clog2(DEPTH);

    cpe_state_t            state_reg;
    cpe_state_t            state_next;
    logic [IDX_W-1:0]      k_reg;
    logic [IDX_W-1:0]      k_next;
    logic [DEG_W-1:0]      degree_reg;
    logic signed [Q_W-1:0] z_re_reg;
    logic signed [Q_W-1:0] z_im_reg;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic                  m_tuser_reg;

    logic                  req_type;
    logic [CIDX_W-1:0]     coef_index;
    logic signed [Q_W-1:0] operand_re;
    logic signed [Q_W-1:0] operand_im;
    logic                  s_accept;
    logic                  idx_ok;
    logic [IDX_W+CIDX_W-1:0] idx_ext;
    logic [IDX_W+DEG_W-1:0]  deg_ext;
    logic [IDX_W-1:0]      wr_addr;
    logic [IDX_W-1:0]      deg_eff;
    logic                  mem_we;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [COEF_W-1:0]     rd_data;
    logic                  out_load;
    cpe_step_t             step;
    logic signed [Q_W-1:0] acc_re;
    logic signed [Q_W-1:0] acc_im;
    logic                  sat_flag;

    // Unpack the input transfer.
    assign req_type   = s_tuser;
    assign coef_index = s_tdata[CIDX_W-1:0];
    assign operand_re = s_tdata[CIDX_W+Q_W-1:CIDX_W];
    assign operand_im = s_tdata[CIDX_W+2*Q_W-1:CIDX_W+Q_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid & s_tready;

    // Slot address for writes and the clamped degree for evaluation.
    assign idx_ext = {{IDX_W{1'b0}}, coef_index};
    assign wr_addr = idx_ext[IDX_W-1:0];
    assign idx_ok  = (int'(coef_index) <= MAX_DEGREE);
    assign deg_ext = {{IDX_W{1'b0}}, degree_reg};
    assign deg_eff = (int'(degree_reg) > MAX_DEGREE) ? IDX_W'(MAX_DEGREE)
                                                     : deg_ext[IDX_W-1:0];
    assign mem_we  = s_accept && (req_type == REQ_WRITE) && idx_ok;

    cpe_coef_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (IDX_W)
    ) u_coef_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_we),
        .wr_addr (wr_addr),
        .wr_data ({operand_im, operand_re}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    cpe_cmac u_cmac (
        .aclk     (aclk),
        .step     (step),
        .z_re     (z_re_reg),
        .z_im     (z_im_reg),
        .coef     (rd_data),
        .acc_re   (acc_re),
        .acc_im   (acc_im),
        .sat_flag (sat_flag)
    );

    // Sequencer state and step counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
        end
    end

    // Next state, memory reads and datapath steps. The input side stays closed
    // during an evaluation, so no write can land on an entry being read.
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        rd_en      = 1'b0;
        rd_addr    = k_reg;
        step       = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (req_type == REQ_EVAL)) begin
                    rd_en      = 1'b1;
                    rd_addr    = deg_eff;
                    k_next     = deg_eff;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                step.load_acc = 1'b1;
                if (k_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = k_reg - IDX_W'(1);
                    k_next     = k_reg - IDX_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                step.mul_en = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD: begin
                step.add_en = 1'b1;
                if (k_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    rd_en      = 1'b1;
                    rd_addr    = k_reg - IDX_W'(1);
                    k_next     = k_reg - IDX_W'(1);
                    state_next = ST_MUL;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Degree register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            degree_reg <= '0;
        end else if (cfg_we) begin
            degree_reg <= cfg_wdata;
        end
    end

    // Evaluation point, captured when an evaluate transfer is taken.
    always_ff @(posedge aclk) begin
        if (s_accept && (req_type == REQ_EVAL)) begin
            z_re_reg <= operand_re;
            z_im_reg <= operand_im;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {acc_im, acc_re};
            m_tuser_reg <= sat_flag;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
